// File: rtl/core/pcpfa_pkg.sv
// ----------------------------------------------------------------------------
// pcpfa_pkg
// Shared types and constants for the per-CPU page free-list allocator.
// ----------------------------------------------------------------------------
package pcpfa_pkg;

  localparam int ADDR_W    = 40;
  localparam int CPU_ID_W  = 3;
  localparam int CFG_IDX_W = 1;

  localparam int NUM_CPUS_DEF   = 8;
  localparam int MAX_PAGES_DEF  = 32768;
  localparam int PAGE_BYTES_DEF = 4096;

  localparam logic [ADDR_W-1:0] MEM_START_RST = 40'h00_0000_0000;
  localparam logic [ADDR_W-1:0] MEM_STOP_RST  = 40'h00_0800_0000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_STOP  = 1'd1;

  typedef enum logic [1:0] {
    STAT_ALLOC    = 2'd0,
    STAT_FREED    = 2'd1,
    STAT_NO_PAGE  = 2'd2,
    STAT_BAD_ADDR = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_LO,
    ST_CHK_HI,
    ST_CHK_LIM,
    ST_POP,
    ST_POP_WAIT
  } fsm_state_t;

  typedef struct packed {
    logic                mode;
    logic [CPU_ID_W-1:0] cpu_id;
    logic [ADDR_W-1:0]   page_address;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   granted_address;
    logic [CPU_ID_W-1:0] source_cpu;
  } out_item_t;

endpackage

// File: rtl/core/pcpfa_link_mem.sv
// ----------------------------------------------------------------------------
// pcpfa_link_mem
// Next-page link memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pcpfa_link_mem
  import pcpfa_pkg::*;
#(
  parameter int DEPTH = MAX_PAGES_DEF,
  parameter int AW    = $clog2(MAX_PAGES_DEF),
  parameter int DW    = $clog2(MAX_PAGES_DEF) + 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/per_cpu_page_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator_top
// Per-CPU LIFO free lists of physical pages, linked through a page-indexed
// next-page memory, with stealing from other lists when the own list is empty.
// ----------------------------------------------------------------------------
// usage:
//   a request beat is taken when start is high and busy is low. in_data.mode
//   selects allocate (0) or free (1); cpu_id names the requesting list.
//   exactly one result beat follows per request, shown on out_data for one
//   cycle with out_valid high; the receiver cannot stall, so it must sample it.
// sequence per request:
//   free: address checks run one per cycle through a single shared
//     41-bit magnitude comparator (mem_start, mem_stop, link memory limit).
//   allocate from own list: head lookup, then link memory read.
//   steal: the lowest non-empty list supplies the page; all lists empty
//     gives a no-page result (one head probed per cycle).
//   busy drops in the cycle that shows the result, so a new request can be
//   taken then; one request is in flight at a time.
// config: cfg_we writes mem_start (index 0) or mem_stop (index 1); write only
//   while busy is low.
// reset: rst_n (synchronous) empties all lists and restores the bounds. the
//   link memory needs no clearing: an entry is always written before read.
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_allocator_top
  import pcpfa_pkg::*;
#(
  parameter int NUM_CPUS   = NUM_CPUS_DEF,
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata
);

  localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int PN_W  = $clog2(MAX_PAGES);
  localparam int OFF_W = $clog2(PAGE_BYTES);
  localparam int CMP_W = ADDR_W + 1;
  localparam logic [CMP_W-1:0] ADDR_LIM = CMP_W'(MAX_PAGES) << OFF_W;
  localparam logic [CPU_W-1:0] LAST_CPU = CPU_W'(NUM_CPUS - 1);

  fsm_state_t          state_r, state_nxt;
  logic [CPU_W-1:0]    idx_r, idx_nxt;
  logic                scan_r, scan_nxt;
  logic                bad_r, bad_nxt;
  logic [ADDR_W-1:0]   addr_r;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic [ADDR_W-1:0]   mem_start_r, mem_stop_r;

  logic                head_vld_r [NUM_CPUS];
  logic [PN_W-1:0]     head_pg_r  [NUM_CPUS];
  logic                head_we;
  logic                head_wvld;
  logic [PN_W-1:0]     head_wpg;

  logic                lnk_we, lnk_re;
  logic [PN_W:0]       lnk_wdata, lnk_rdata_r;
  logic [PN_W-1:0]     lnk_raddr, pn;

  logic [CMP_W-1:0]    cmp_b;
  logic                cmp_lt;
  logic [CPU_ID_W-1:0] cpu_red;
  logic [CPU_W-1:0]    req_idx;

  // cpu_id modulo NUM_CPUS by repeated subtract
  always_comb begin
    cpu_red = in_data.cpu_id;
    for (int k = 0; k < 8; k++) begin
      if (int'(cpu_red) >= NUM_CPUS) begin
        cpu_red = cpu_red - CPU_ID_W'(NUM_CPUS);
      end
    end
    req_idx = CPU_W'(cpu_red);
  end

  // shared comparator: address against one bound per cycle
  always_comb begin
    case (state_r)
      ST_CHK_LO: cmp_b = {1'b0, mem_start_r};
      ST_CHK_HI: cmp_b = {1'b0, mem_stop_r};
      default:   cmp_b = ADDR_LIM;
    endcase
    cmp_lt = {1'b0, addr_r} < cmp_b;
  end

  assign pn = addr_r[OFF_W +: PN_W];

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    scan_nxt      = scan_r;
    bad_nxt       = bad_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    head_we       = 1'b0;
    head_wvld     = 1'b1;
    head_wpg      = pn;
    lnk_we        = 1'b0;
    lnk_re        = 1'b0;
    lnk_raddr     = head_pg_r[idx_r];
    lnk_wdata     = {head_vld_r[idx_r], head_pg_r[idx_r]};
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          idx_nxt   = req_idx;
          scan_nxt  = 1'b0;
          bad_nxt   = 1'b0;
          state_nxt = in_data.mode ? ST_CHK_LO : ST_POP;
        end
      end
      ST_CHK_LO: begin
        bad_nxt   = (addr_r[OFF_W-1:0] != '0) | cmp_lt;
        state_nxt = ST_CHK_HI;
      end
      ST_CHK_HI: begin
        bad_nxt   = bad_r | !cmp_lt;
        state_nxt = ST_CHK_LIM;
      end
      ST_CHK_LIM: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_data_nxt.granted_address = '0;
        out_data_nxt.source_cpu      = '0;
        if (bad_r | !cmp_lt) begin
          out_data_nxt.status = STAT_BAD_ADDR;
        end else begin
          // push: old head becomes this page's link
          lnk_we  = 1'b1;
          head_we = 1'b1;
          out_data_nxt.status = STAT_FREED;
        end
      end
      ST_POP: begin
        if (head_vld_r[idx_r]) begin
          lnk_re    = 1'b1;
          state_nxt = ST_POP_WAIT;
        end else if (!scan_r) begin
          idx_nxt  = '0;
          scan_nxt = 1'b1;
        end else if (idx_r == LAST_CPU) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt.status          = STAT_NO_PAGE;
          out_data_nxt.granted_address = '0;
          out_data_nxt.source_cpu      = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_POP_WAIT: begin
        head_we       = 1'b1;
        head_wvld     = lnk_rdata_r[PN_W];
        head_wpg      = lnk_rdata_r[PN_W-1:0];
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_data_nxt.status          = STAT_ALLOC;
        out_data_nxt.granted_address = ADDR_W'(head_pg_r[idx_r]) << OFF_W;
        out_data_nxt.source_cpu      = CPU_ID_W'(idx_r);
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      scan_r      <= 1'b0;
      bad_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      scan_r      <= scan_nxt;
      bad_r       <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (state_r == ST_IDLE && start) begin
      addr_r <= in_data.page_address;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CPUS; c++) begin
        head_vld_r[c] <= 1'b0;
      end
    end else if (head_we) begin
      head_vld_r[idx_r] <= head_wvld;
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_pg_r[idx_r] <= head_wpg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_start_r <= MEM_START_RST;
      mem_stop_r  <= MEM_STOP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MEM_START: mem_start_r <= cfg_wdata;
        CFG_MEM_STOP:  mem_stop_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pcpfa_link_mem #(
    .DEPTH (MAX_PAGES),
    .AW    (PN_W),
    .DW    (PN_W + 1)
  ) u_link_mem (
    .clk     (clk),
    .we      (lnk_we),
    .waddr   (pn),
    .wdata   (lnk_wdata),
    .re      (lnk_re),
    .raddr   (lnk_raddr),
    .rdata_r (lnk_rdata_r)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: tb/pcpfa_checker.sv
// ----------------------------------------------------------------------------
// pcpfa_checker
// Watches the request, result and configuration ports of the page allocator,
// keeps its own copy of the per-CPU free lists and the address bounds, and
// compares every result beat field by field with the oldest predicted reply.
// ----------------------------------------------------------------------------
module pcpfa_checker
  import pcpfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  output int                   fail_count,
  output int                   open_requests
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PG_W = $clog2(MAX_PAGES_DEF);
  typedef logic [PG_W-1:0] page_t;

  logic              head_ok [NUM_CPUS_DEF];
  page_t             head_pg [NUM_CPUS_DEF];
  logic              link_ok [MAX_PAGES_DEF];
  page_t             link_pg [MAX_PAGES_DEF];
  logic [ADDR_W-1:0] lo_bound;
  logic [ADDR_W-1:0] hi_bound;
  out_item_t         replies_due [$];
  int                errs = 0;

  // pop the head of one cpu's list
  function automatic bit take_page(int cpu, output page_t pg);
    if (!head_ok[cpu]) return 1'b0;
    pg = head_pg[cpu];
    head_ok[cpu] = link_ok[pg];
    head_pg[cpu] = link_pg[pg];
    return 1'b1;
  endfunction

  function automatic out_item_t serve_request(in_item_t req);
    out_item_t         res;
    int                cpu;
    page_t             pg;
    logic [ADDR_W-1:0] a;
    bit                got;
    res.status          = STAT_ALLOC;
    res.granted_address = '0;
    res.source_cpu      = '0;
    cpu = int'(req.cpu_id) % NUM_CPUS_DEF;
    a   = req.page_address;
    if (req.mode) begin
      // free: alignment, both bounds and the link memory size
      if ((a % PAGE_BYTES_DEF) != 0 || a < lo_bound || a >= hi_bound ||
          (a / PAGE_BYTES_DEF) >= MAX_PAGES_DEF) begin
        res.status = STAT_BAD_ADDR;
      end else begin
        pg = page_t'(a / PAGE_BYTES_DEF);
        link_ok[pg]  = head_ok[cpu];
        link_pg[pg]  = head_pg[cpu];
        head_ok[cpu] = 1'b1;
        head_pg[cpu] = pg;
        res.status   = STAT_FREED;
      end
    end else begin
      got = take_page(cpu, pg);
      // own list empty: steal from the lowest non-empty list
      for (int i = 0; i < NUM_CPUS_DEF && !got; i++) begin
        got = take_page(i, pg);
        if (got) cpu = i;
      end
      if (got) begin
        res.status          = STAT_ALLOC;
        res.granted_address = ADDR_W'(ADDR_W'(pg) * PAGE_BYTES_DEF);
        res.source_cpu      = CPU_ID_W'(cpu);
      end else begin
        res.status = STAT_NO_PAGE;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t due;
    if (!rst_n) begin
      for (int i = 0; i < NUM_CPUS_DEF; i++) begin
        head_ok[i] = 1'b0;
        head_pg[i] = '0;
      end
      lo_bound = MEM_START_RST;
      hi_bound = MEM_STOP_RST;
      replies_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MEM_START) lo_bound = cfg_wdata;
        else if (cfg_index == CFG_MEM_STOP) hi_bound = cfg_wdata;
      end
      if (out_valid === 1'b1) begin
        if (replies_due.size() == 0) begin
          errs++;
          $error("result beat with no request outstanding");
        end else begin
          due = replies_due.pop_front();
          if (out_data.status !== due.status) begin
            errs++;
            $error("status: expected %0d, got %0d", due.status, out_data.status);
          end
          if (out_data.granted_address !== due.granted_address) begin
            errs++;
            $error("granted_address: expected %h, got %h",
                   due.granted_address, out_data.granted_address);
          end
          if (out_data.source_cpu !== due.source_cpu) begin
            errs++;
            $error("source_cpu: expected %0d, got %0d",
                   due.source_cpu, out_data.source_cpu);
          end
        end
      end
      // a result and the next request can share an edge: result first
      if (start && !busy) replies_due.push_back(serve_request(in_data));
    end
    open_requests <= replies_due.size();
    fail_count    <= errs;
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the per-CPU page free-list allocator: directed boundary and
// steal cases, then random request streams under several address windows,
// with random gaps between request beats. Checking is done by pcpfa_checker.
// ----------------------------------------------------------------------------
module tb
  import pcpfa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;
  localparam logic [ADDR_W-1:0] ADDR_TOP = 40'hFF_FFFF_FFFF;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_data;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_wdata;
  int                   fail_count;
  int                   open_requests;

  logic [ADDR_W-1:0] cur_lo;
  logic [ADDR_W-1:0] cur_hi;
  int                pg_seq;
  bit                no_idle;

  per_cpu_page_free_list_allocator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pcpfa_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .open_requests (open_requests)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {8'($urandom()), $urandom()};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mostly fresh pages inside the window, the rest malformed or out of range
  function automatic logic [ADDR_W-1:0] free_address();
    longint            lo_pg;
    longint            hi_pg;
    longint            span;
    int                r;
    logic [ADDR_W-1:0] a;
    lo_pg = (longint'(cur_lo) + PAGE_BYTES_DEF - 1) / PAGE_BYTES_DEF;
    hi_pg = (longint'(cur_hi) + PAGE_BYTES_DEF - 1) / PAGE_BYTES_DEF;
    if (hi_pg > MAX_PAGES_DEF) hi_pg = MAX_PAGES_DEF;
    span = hi_pg - lo_pg;
    r = $urandom_range(0, 99);
    if (span > 0 && r < 80) begin
      a = ADDR_W'((lo_pg + pg_seq % span) * PAGE_BYTES_DEF);
      pg_seq++;
    end else begin
      case (r % 5)
        0: a = rand_addr();
        1: begin
          a = rand_addr();
          a[11:0] = 12'($urandom_range(1, PAGE_BYTES_DEF - 1));
        end
        2: a = ADDR_W'((lo_pg - 1) * PAGE_BYTES_DEF);
        3: a = ADDR_W'(hi_pg * PAGE_BYTES_DEF);
        default: a = ADDR_W'((longint'(MAX_PAGES_DEF) + $urandom_range(0, 1000)) *
                             PAGE_BYTES_DEF);
      endcase
    end
    return a;
  endfunction

  task automatic send(logic m, logic [CPU_ID_W-1:0] c, logic [ADDR_W-1:0] a);
    in_item_t it;
    int       gap;
    it.mode         = m;
    it.cpu_id       = c;
    it.page_address = a;
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy !== 1'b0);
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every outstanding beat has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (open_requests != 0 || busy !== 1'b0);
  endtask

  task automatic set_bounds(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MEM_START;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_MEM_STOP;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
  endtask

  task automatic run_random(int count);
    int                pct;
    logic              m;
    logic [ADDR_W-1:0] a;
    for (int k = 0; k < count; k++) begin
      // vary the free/alloc mix so lists both fill up and run dry
      if (k % 32 == 0) begin
        case ($urandom_range(0, 3))
          0: pct = 25;
          1: pct = 50;
          2: pct = 75;
          default: pct = 90;
        endcase
        no_idle = ($urandom_range(0, 3) == 0);
      end
      m = ($urandom_range(0, 99) < pct) ? MODE_FREE : MODE_ALLOC;
      a = (m == MODE_FREE) ? free_address() : rand_addr();
      send(m, CPU_ID_W'($urandom_range(0, 7)), a);
      if ($urandom_range(0, 149) == 0) drain();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_MEM_START;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    cur_lo    = MEM_START_RST;
    cur_hi    = MEM_STOP_RST;
    pg_seq    = 0;
    no_idle   = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all lists empty
    send(MODE_ALLOC, 0, rand_addr());
    send(MODE_ALLOC, 7, ADDR_TOP);
    // lowest and highest page, then rejects and one good page for cpu 5
    send(MODE_FREE, 3, 40'h0);
    send(MODE_FREE, 3, 40'h00_07FF_F000);
    send(MODE_FREE, 3, MEM_STOP_RST);
    send(MODE_FREE, 3, 40'h00_0000_1001);
    send(MODE_FREE, 3, 40'h00_0000_0800);
    send(MODE_FREE, 5, 40'hFF_FFFF_F000);
    send(MODE_FREE, 5, 40'h00_0000_2000);
    // own list, steals from 3 and 5, then all lists empty
    send(MODE_ALLOC, 3, rand_addr());
    send(MODE_ALLOC, 0, rand_addr());
    send(MODE_ALLOC, 0, rand_addr());
    send(MODE_ALLOC, 1, rand_addr());
    // steal from the last cpu
    send(MODE_FREE, 7, 40'h00_0000_3000);
    send(MODE_ALLOC, 6, rand_addr());
    // same page freed onto two lists
    send(MODE_FREE, 1, 40'h00_0000_5000);
    send(MODE_FREE, 2, 40'h00_0000_5000);
    send(MODE_ALLOC, 1, rand_addr());
    send(MODE_ALLOC, 2, rand_addr());
    send(MODE_ALLOC, 0, rand_addr());

    set_bounds(40'h00_0001_0000, 40'h00_0002_0000);
    send(MODE_FREE, 4, 40'h00_0000_F000);
    send(MODE_FREE, 4, 40'h00_0001_0000);
    send(MODE_FREE, 4, 40'h00_0001_F000);
    send(MODE_FREE, 4, 40'h00_0002_0000);
    // window past the link memory
    set_bounds(40'h00_0001_0000, ADDR_TOP);
    send(MODE_FREE, 4, 40'h00_0800_0000);
    send(MODE_FREE, 4, 40'h00_07FF_F000);
    send(MODE_ALLOC, 2, rand_addr());
    send(MODE_ALLOC, 2, rand_addr());
    send(MODE_ALLOC, 2, rand_addr());

    set_bounds(40'h00_0010_0000, 40'h00_0200_0000);
    run_random(250);
    set_bounds(40'h0, ADDR_TOP);
    run_random(250);
    set_bounds(ADDR_TOP, 40'h0);
    run_random(60);
    set_bounds(40'h00_0400_1000, 40'h00_0404_1000);
    run_random(90);
    set_bounds(MEM_START_RST, MEM_STOP_RST);
    run_random(200);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule
